[design/crc16prp_pkg.sv]
// ----------------------------------------------------------------------------
// crc16prp_pkg
// Shared types and constants of the crc16 framed packet receive parser.
// ----------------------------------------------------------------------------
package crc16prp_pkg;

  // parse phases of the receive state machine
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CMD     = 3'd1,
    PH_SEQ     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6
  } phase_t;

  // event codes on the result channel
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_DATA   = 3'd1;
  localparam logic [2:0] EV_GOOD   = 3'd2;
  localparam logic [2:0] EV_BAD    = 3'd3;
  localparam logic [2:0] EV_REJECT = 3'd4;

  // crc-16-ccitt, unreflected, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration port: two 8-bit registers, read as 32-bit words, at byte addresses 0 and 4
  localparam int CFG_AW = 3;
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_MAX_PAYLOAD  = 1'b1;
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd64;

  // one result item
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [7:0]  length;
    logic [15:0] crc_computed;
    logic [15:0] crc_frame;
    logic [31:0] good_count;
    logic [31:0] crc_error_count;
  } result_t;

endpackage

[design/crc16prp_if.sv]
// ----------------------------------------------------------------------------
// crc16prp_if
// Valid/ready channels of the parser: received bytes in, results out.
// ----------------------------------------------------------------------------
interface crc16prp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc16prp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  command;
  logic [7:0]  sequence_res;
  logic [7:0]  length;
  logic [15:0] crc_computed;
  logic [15:0] crc_frame;
  logic [31:0] good_count;
  logic [31:0] crc_error_count;

  modport source (
    output valid, output event_res, output payload_byte, output payload_index,
    output command, output sequence_res, output length, output crc_computed,
    output crc_frame, output good_count, output crc_error_count, input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input payload_index,
    input command, input sequence_res, input length, input crc_computed,
    input crc_frame, input good_count, input crc_error_count, output ready
  );
endinterface

[design/crc16prp_crc_byte.sv]
// ----------------------------------------------------------------------------
// crc16prp_crc_byte
// One-byte update of crc-16-ccitt (poly 0x1021, msb first).
// ----------------------------------------------------------------------------
module crc16prp_crc_byte
  import crc16prp_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  // eight shift steps over the data byte folded into the high half
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[design/crc16_packet_receive_parser.sv]
// ----------------------------------------------------------------------------
// crc16_packet_receive_parser
// Framed packet receiver with incremental crc-16-ccitt check.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per request. While idle the parser waits
//   for the start marker, then takes command, sequence and length bytes,
//   the payload and a big-endian crc. out_ch gives exactly one result per
//   byte: event code, payload byte and index, header bytes, crcs at packet
//   end and the good / crc error counters.
//   The byte lands in an input register, and the phase machine plus a
//   one-byte crc update fill the result register from it. Throughput is
//   one byte per cycle while the result side takes results, set by the
//   single byte-wide crc step between those two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; in_ch.ready drops only when both
//   are full and the result is not being taken.
//   Synchronous reset empties both registers, returns the parser to idle,
//   clears the counters and loads start marker 0xAA and max payload 64.
//   cfg_*: APB-style port, start_marker at 0x0, max_payload at 0x4.
// ----------------------------------------------------------------------------
module crc16_packet_receive_parser
  import crc16prp_pkg::*;
#(
  parameter int COUNTER_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  crc16prp_in_if.sink       in_ch,
  crc16prp_out_if.source    out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // configuration registers
  logic [7:0] start_marker_r;
  logic [7:0] max_payload_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      max_payload_r  <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[CFG_AW-1] == REG_START_MARKER) begin
        start_marker_r <= cfg_pwdata[7:0];
      end else begin
        max_payload_r <= cfg_pwdata[7:0];
      end
    end
  end

  // register read back
  always_comb begin
    if (cfg_paddr[CFG_AW-1] == REG_START_MARKER) begin
      cfg_prdata = {24'h0, start_marker_r};
    end else begin
      cfg_prdata = {24'h0, max_payload_r};
    end
  end

  // handshake of input and result registers
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       out_vld_r;
  result_t    out_r;
  result_t    res_nxt;
  logic       out_free;
  logic       s1_adv;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign s1_adv      = s1_vld_r && out_free;
  assign in_ch.ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  // parser state
  phase_t                  phase_r,    phase_nxt;
  logic [7:0]              cmd_r,      cmd_nxt;
  logic [7:0]              seq_r,      seq_nxt;
  logic [7:0]              len_r,      len_nxt;
  logic [7:0]              taken_r,    taken_nxt;
  logic [15:0]             crc_r,      crc_nxt;
  logic [7:0]              crc_hi_r,   crc_hi_nxt;
  logic [COUNTER_BITS-1:0] good_r,     good_nxt;
  logic [COUNTER_BITS-1:0] fail_r,     fail_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cmd_r    <= 8'h00;
      seq_r    <= 8'h00;
      len_r    <= 8'h00;
      taken_r  <= 8'h00;
      crc_r    <= CRC_INIT;
      crc_hi_r <= 8'h00;
      good_r   <= '0;
      fail_r   <= '0;
    end else if (s1_adv) begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      taken_r  <= taken_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
      good_r   <= good_nxt;
      fail_r   <= fail_nxt;
    end
  end

  // byte-wide crc step on the held byte
  logic [15:0] crc_upd;

  crc16prp_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (s1_byte_r),
    .crc_out (crc_upd)
  );

  // next phase and result
  logic [7:0]  taken_inc;
  logic [2:0]  ev;
  logic [7:0]  pbyte;
  logic [7:0]  pidx;
  logic [15:0] crc_c;
  logic [15:0] crc_rcv;
  logic [63:0] good_ext;
  logic [63:0] fail_ext;

  assign taken_inc = taken_r + 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    taken_nxt  = taken_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    good_nxt   = good_r;
    fail_nxt   = fail_r;
    ev         = EV_NONE;
    pbyte      = 8'h00;
    pidx       = 8'h00;
    crc_c      = 16'h0000;
    crc_rcv    = 16'h0000;
    unique case (phase_r)
      PH_IDLE: begin
        if (s1_byte_r == start_marker_r) begin
          phase_nxt = PH_CMD;
          taken_nxt = 8'h00;
          crc_nxt   = CRC_INIT;
        end
      end
      PH_CMD: begin
        cmd_nxt   = s1_byte_r;
        crc_nxt   = crc_upd;
        phase_nxt = PH_SEQ;
      end
      PH_SEQ: begin
        seq_nxt   = s1_byte_r;
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = s1_byte_r;
        crc_nxt = crc_upd;
        if (s1_byte_r == 8'h00) begin
          phase_nxt = PH_CRC_HI;
        end else if (s1_byte_r > max_payload_r) begin
          phase_nxt = PH_IDLE;
          ev        = EV_REJECT;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ev        = EV_DATA;
        pbyte     = s1_byte_r;
        pidx      = taken_r;
        crc_nxt   = crc_upd;
        taken_nxt = taken_inc;
        // last byte, or index wrapped past 255
        if (taken_inc >= len_r || taken_inc == 8'h00) begin
          phase_nxt = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_hi_nxt = s1_byte_r;
        phase_nxt  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_rcv = {crc_hi_r, s1_byte_r};
        crc_c   = crc_r;
        if (crc_r == crc_rcv) begin
          good_nxt = good_r + 1'b1;
          ev       = EV_GOOD;
        end else begin
          fail_nxt = fail_r + 1'b1;
          ev       = EV_BAD;
        end
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // counters reported as their low 32 bits
  assign good_ext = 64'(good_nxt);
  assign fail_ext = 64'(fail_nxt);

  always_comb begin
    res_nxt.event_res       = ev;
    res_nxt.payload_byte    = pbyte;
    res_nxt.payload_index   = pidx;
    res_nxt.command         = cmd_nxt;
    res_nxt.sequence_res    = seq_nxt;
    res_nxt.length          = len_nxt;
    res_nxt.crc_computed    = crc_c;
    res_nxt.crc_frame       = crc_rcv;
    res_nxt.good_count      = good_ext[31:0];
    res_nxt.crc_error_count = fail_ext[31:0];
  end

  // result channel drive
  assign out_ch.valid           = out_vld_r;
  assign out_ch.event_res       = out_r.event_res;
  assign out_ch.payload_byte    = out_r.payload_byte;
  assign out_ch.payload_index   = out_r.payload_index;
  assign out_ch.command         = out_r.command;
  assign out_ch.sequence_res    = out_r.sequence_res;
  assign out_ch.length          = out_r.length;
  assign out_ch.crc_computed    = out_r.crc_computed;
  assign out_ch.crc_frame       = out_r.crc_frame;
  assign out_ch.good_count      = out_r.good_count;
  assign out_ch.crc_error_count = out_r.crc_error_count;

endmodule

[design/crc16prp_checker.sv]
// ----------------------------------------------------------------------------
// crc16prp_checker
// Port-level assertions of the parser, attached by bind.
// ----------------------------------------------------------------------------
module crc16prp_checker
  import crc16prp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  crc16prp_in_if.sink     in_ch,
  crc16prp_out_if.source  out_ch
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // payload fields are zero outside a payload event
  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res != EV_DATA |->
      out_ch.payload_byte == 8'h00 && out_ch.payload_index == 8'h00)
    else $error("payload fields set outside a payload event");

  // input stalls only behind a blocked result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled with the result side free");

  // good verdict only with matching crcs
  a_good_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res == EV_GOOD |->
      out_ch.crc_computed == out_ch.crc_frame)
    else $error("good packet reported with crc mismatch");

endmodule

bind crc16_packet_receive_parser crc16prp_checker u_crc16prp_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

[verif/tb_crc16_packet_receive_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc16_packet_receive_parser
// Self-checking bench for the crc16 framed packet receive parser. A short
// table of directed bytes covers reset values, zero and rejected lengths,
// good and bad crcs and the marker inside a packet. Random framed packets
// follow, with noise, corrupted crcs and cut-off frames, over several
// marker / max payload settings. Every result is checked against a
// byte-level model of the parser kept inside the bench.
// ----------------------------------------------------------------------------
module tb_crc16_packet_receive_parser;
  import crc16prp_pkg::*;

  localparam int TOTAL_ITEMS = 850;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  // how a directed row gets its byte
  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_CRC_HI,
    SRC_CRC_LO,
    SRC_CRC_LO_BAD
  } byte_src_t;

  typedef struct packed {
    byte_src_t  src;
    logic [7:0] lit;
    logic       typed;
    logic [2:0] ev;
  } dir_row_t;

  logic clk;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  crc16prp_in_if  in_bus ();
  crc16prp_out_if out_bus ();

  crc16_packet_receive_parser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // parser model state and register copies
  phase_t      rx_phase;
  logic [7:0]  hdr_cmd;
  logic [7:0]  hdr_seq;
  logic [7:0]  hdr_len;
  logic [7:0]  pay_count;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi_byte;
  logic [31:0] good_pkts;
  logic [31:0] bad_pkts;
  logic [7:0]  cur_marker;
  logic [7:0]  cur_max_len;

  result_t     pending_results[$];
  int          mismatches;
  int          sent_items;
  bit          calm;
  int unsigned sink_wait;

  dir_row_t dir_rows [20] = '{
    // idle bytes right after reset
    '{SRC_LIT, 8'h00, 1'b1, EV_NONE},
    '{SRC_LIT, 8'hFF, 1'b1, EV_NONE},
    // zero length packet, header extremes, good crc
    '{SRC_LIT, START_MARKER_RST, 1'b1, EV_NONE},
    '{SRC_LIT, 8'hFF, 1'b1, EV_NONE},
    '{SRC_LIT, 8'h00, 1'b1, EV_NONE},
    '{SRC_LIT, 8'h00, 1'b1, EV_NONE},
    '{SRC_CRC_HI, 8'h00, 1'b1, EV_NONE},
    '{SRC_CRC_LO, 8'h00, 1'b1, EV_GOOD},
    // one byte payload equal to the marker, bad crc
    '{SRC_LIT, START_MARKER_RST, 1'b1, EV_NONE},
    '{SRC_LIT, 8'h12, 1'b1, EV_NONE},
    '{SRC_LIT, 8'h34, 1'b1, EV_NONE},
    '{SRC_LIT, 8'h01, 1'b1, EV_NONE},
    '{SRC_LIT, START_MARKER_RST, 1'b0, EV_NONE},
    '{SRC_CRC_HI, 8'h00, 1'b1, EV_NONE},
    '{SRC_CRC_LO_BAD, 8'h00, 1'b1, EV_BAD},
    // length one over the maximum
    '{SRC_LIT, START_MARKER_RST, 1'b1, EV_NONE},
    '{SRC_LIT, 8'h80, 1'b1, EV_NONE},
    '{SRC_LIT, 8'h7F, 1'b1, EV_NONE},
    '{SRC_LIT, MAX_PAYLOAD_RST + 8'd1, 1'b1, EV_REJECT},
    '{SRC_LIT, 8'h55, 1'b1, EV_NONE}
  };

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // one byte of crc-16-ccitt, msb first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  // advance the parser model by one byte and return its result
  function result_t parse_step(logic [7:0] b);
    result_t r;
    r = '0;
    r.event_res = EV_NONE;
    case (rx_phase)
      PH_IDLE: begin
        if (b == cur_marker) begin
          rx_phase = PH_CMD;
          pay_count = 8'd0;
          crc_acc = CRC_INIT;
        end
      end
      PH_CMD: begin
        hdr_cmd = b;
        crc_acc = crc16_byte(crc_acc, b);
        rx_phase = PH_SEQ;
      end
      PH_SEQ: begin
        hdr_seq = b;
        crc_acc = crc16_byte(crc_acc, b);
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        hdr_len = b;
        crc_acc = crc16_byte(crc_acc, b);
        if (b == 8'd0) begin
          rx_phase = PH_CRC_HI;
        end else if (b > cur_max_len) begin
          rx_phase = PH_IDLE;
          r.event_res = EV_REJECT;
        end else begin
          rx_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.event_res = EV_DATA;
        r.payload_byte = b;
        r.payload_index = pay_count;
        crc_acc = crc16_byte(crc_acc, b);
        pay_count = pay_count + 8'd1;
        if (pay_count >= hdr_len || pay_count == 8'd0) rx_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi_byte = b;
        rx_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        r.crc_frame = {crc_hi_byte, b};
        r.crc_computed = crc_acc;
        if (crc_acc == {crc_hi_byte, b}) begin
          good_pkts = good_pkts + 32'd1;
          r.event_res = EV_GOOD;
        end else begin
          bad_pkts = bad_pkts + 32'd1;
          r.event_res = EV_BAD;
        end
        rx_phase = PH_IDLE;
      end
      default: rx_phase = PH_IDLE;
    endcase
    r.command = hdr_cmd;
    r.sequence_res = hdr_seq;
    r.length = hdr_len;
    r.good_count = good_pkts;
    r.crc_error_count = bad_pkts;
    return r;
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task check_result(result_t got, result_t want);
    if (got.event_res !== want.event_res)
      report_mismatch("event_res", got.event_res, want.event_res);
    if (got.payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
    if (got.payload_index !== want.payload_index)
      report_mismatch("payload_index", got.payload_index, want.payload_index);
    if (got.command !== want.command)
      report_mismatch("command", got.command, want.command);
    if (got.sequence_res !== want.sequence_res)
      report_mismatch("sequence_res", got.sequence_res, want.sequence_res);
    if (got.length !== want.length)
      report_mismatch("length", got.length, want.length);
    if (got.crc_computed !== want.crc_computed)
      report_mismatch("crc_computed", got.crc_computed, want.crc_computed);
    if (got.crc_frame !== want.crc_frame)
      report_mismatch("crc_frame", got.crc_frame, want.crc_frame);
    if (got.good_count !== want.good_count)
      report_mismatch("good_count", got.good_count, want.good_count);
    if (got.crc_error_count !== want.crc_error_count)
      report_mismatch("crc_error_count", got.crc_error_count, want.crc_error_count);
  endtask

  // send one byte after a random gap; predict its result once accepted
  task send_byte(logic [7:0] b, logic typed, logic [2:0] typed_ev);
    int unsigned gap;
    result_t r;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    sent_items++;
    r = parse_step(b);
    if (typed) r.event_res = typed_ev;
    pending_results.push_back(r);
  endtask

  // register write: setup cycle, then access cycle until pready
  task cfg_write(logic idx, logic [7:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_START_MARKER) cur_marker = value;
    else cur_max_len = value;
  endtask

  // register read back against the copy
  task cfg_check(logic idx);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== ((idx == REG_START_MARKER) ? cur_marker : cur_max_len))
      report_mismatch("register readback", cfg_prdata[7:0],
                      (idx == REG_START_MARKER) ? cur_marker : cur_max_len);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // stop sending and wait until every pending result has come back
  task settle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // noise, then a framed packet; some rejected, corrupted or cut short
  task automatic send_random_packet();
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [7:0]  len;
    logic [15:0] crc;
    int unsigned kind;
    int unsigned keep;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(0, 255));
      if (b == cur_marker) b = ~b;
      send_byte(b, 1'b0, EV_NONE);
    end
    if (kind < 8 && cur_max_len != 8'hFF) begin
      len = 8'($urandom_range(cur_max_len + 1, 255));
    end else if (kind < 11) begin
      len = cur_max_len;
    end else if ($urandom_range(0, 3) == 0) begin
      len = 8'($urandom_range(0, cur_max_len));
    end else begin
      len = 8'($urandom_range(0, (cur_max_len < 6) ? cur_max_len : 6));
    end
    frame.push_back(cur_marker);
    crc = CRC_INIT;
    repeat (2) begin
      b = 8'($urandom_range(0, 255));
      frame.push_back(b);
      crc = crc16_byte(crc, b);
    end
    frame.push_back(len);
    crc = crc16_byte(crc, len);
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      frame.push_back(b);
      crc = crc16_byte(crc, b);
    end
    if (kind >= 11 && kind < 26) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    keep = frame.size();
    if (len > cur_max_len) keep = 4;
    else if (kind >= 26 && kind < 33) keep = $urandom_range(1, frame.size() - 1);
    for (int i = 0; i < keep; i++) send_byte(frame[i], 1'b0, EV_NONE);
  endtask

  // result side: random stall after each accepted result
  always @(posedge clk) begin
    int unsigned w;
    if (!rst_n) begin
      out_bus.ready <= 1'b1;
      sink_wait <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      w = calm ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_bus.ready <= 1'b0;
        sink_wait <= w;
      end
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      if (sink_wait == 1) out_bus.ready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.event_res = out_bus.event_res;
      got.payload_byte = out_bus.payload_byte;
      got.payload_index = out_bus.payload_index;
      got.command = out_bus.command;
      got.sequence_res = out_bus.sequence_res;
      got.length = out_bus.length;
      got.crc_computed = out_bus.crc_computed;
      got.crc_frame = out_bus.crc_frame;
      got.good_count = out_bus.good_count;
      got.crc_error_count = out_bus.crc_error_count;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", got.event_res, EV_NONE);
      end else begin
        check_result(got, pending_results.pop_front());
      end
    end
  end

  // watchdog on cycles without any request moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // main sequence
  initial begin
    int phase_no;
    int phase_end;
    logic [7:0] b;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.rx_byte <= 8'd0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= 32'd0;
    mismatches = 0;
    sent_items = 0;
    calm = 1'b0;
    rx_phase = PH_IDLE;
    hdr_cmd = 8'd0;
    hdr_seq = 8'd0;
    hdr_len = 8'd0;
    pay_count = 8'd0;
    crc_acc = CRC_INIT;
    crc_hi_byte = 8'd0;
    good_pkts = 32'd0;
    bad_pkts = 32'd0;
    cur_marker = START_MARKER_RST;
    cur_max_len = MAX_PAYLOAD_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset values of the registers
    cfg_check(REG_START_MARKER);
    cfg_check(REG_MAX_PAYLOAD);

    // directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].src)
        SRC_CRC_HI:     b = crc_acc[15:8];
        SRC_CRC_LO:     b = crc_acc[7:0];
        SRC_CRC_LO_BAD: b = ~crc_acc[7:0];
        default:        b = dir_rows[i].lit;
      endcase
      send_byte(b, dir_rows[i].typed, dir_rows[i].ev);
    end

    // random phases, each with its own register setting
    phase_no = 0;
    while (sent_items < TOTAL_ITEMS) begin
      settle();
      case (phase_no % 6)
        1: begin
          cfg_write(REG_START_MARKER, 8'($urandom_range(0, 255)));
          cfg_write(REG_MAX_PAYLOAD, 8'd0);
        end
        2: begin
          cfg_write(REG_START_MARKER, 8'($urandom_range(0, 255)));
          cfg_write(REG_MAX_PAYLOAD, 8'hFF);
        end
        3: begin
          cfg_write(REG_START_MARKER, 8'h00);
          cfg_write(REG_MAX_PAYLOAD, 8'($urandom_range(1, 255)));
        end
        4: begin
          cfg_write(REG_START_MARKER, 8'hFF);
          cfg_write(REG_MAX_PAYLOAD, 8'($urandom_range(1, 32)));
        end
        default: begin
          cfg_write(REG_START_MARKER, 8'($urandom_range(0, 255)));
          cfg_write(REG_MAX_PAYLOAD, 8'($urandom_range(1, 255)));
        end
      endcase
      cfg_check(REG_START_MARKER);
      cfg_check(REG_MAX_PAYLOAD);
      calm = ($urandom_range(0, 3) == 0);
      phase_end = sent_items + 110;
      while (sent_items < phase_end && sent_items < TOTAL_ITEMS) send_random_packet();
      phase_no++;
    end

    // drain and finish
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/crc16prp_pkg.sv
design/crc16prp_if.sv
design/crc16prp_crc_byte.sv
design/crc16_packet_receive_parser.sv
design/crc16prp_checker.sv
verif/tb_crc16_packet_receive_parser.sv
